>>> rtl/sbr_pkg.sv
// Shared types and constants for the SBUS frame receiver.
package sbr_pkg;

  localparam int PAYLOAD_BYTES = 24;
  localparam int FLAG_BYTE_IDX = 22;
  localparam int CHAN_BYTES    = 22;
  localparam int CHAN_COUNT    = 16;
  localparam int CHAN_W        = 11;
  localparam int SLOT_W        = $clog2(PAYLOAD_BYTES);
  localparam int MEM_DEPTH     = 2 * PAYLOAD_BYTES;
  localparam int MEM_AW        = $clog2(MEM_DEPTH);
  localparam int CFG_IDX_W     = 8;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_HEADER     = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FOOTER     = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ALT_MASK   = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ALT_FOOTER = 8'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LOST_MASK  = 8'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FS_MASK    = 8'd5;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       gap_timeout;
  } in_item_t;

  typedef struct packed {
    logic [3:0]        channel_index;
    logic [CHAN_W-1:0] channel_value;
    logic              failsafe_flag;
    logic              lost_frame_flag;
    logic              last_channel;
  } out_item_t;

  typedef struct packed {
    logic [7:0] header_value;
    logic [7:0] footer_value;
    logic [7:0] alt_footer_mask;
    logic [7:0] alt_footer_value;
    logic [7:0] lost_frame_mask;
    logic [7:0] failsafe_mask;
  } cfg_regs_t;

  // Parser -> top: memory write and end-of-frame event
  typedef struct packed {
    logic              wr_en;
    logic [SLOT_W-1:0] wr_slot;
    logic [7:0]        wr_data;
    logic              frame_good;
    logic [7:0]        flag_byte;
  } parse_evt_t;

  // Top -> unpacker: start of a frame drain
  typedef struct packed {
    logic start;
    logic bank;
    logic failsafe;
    logic lost_frame;
  } drain_cmd_t;

  // Unpacker -> memory: read request
  typedef struct packed {
    logic              en;
    logic [MEM_AW-1:0] addr;
  } mem_rd_t;

endpackage

>>> rtl/sbr_payload_mem.sv
// Two-bank payload memory, one write port and one registered read port.
module sbr_payload_mem
  import sbr_pkg::*;
(
  input  logic              clk,
  input  logic              wr_en,
  input  logic [MEM_AW-1:0] wr_addr,
  input  logic [7:0]        wr_data,
  input  mem_rd_t           rd_req,
  output logic [7:0]        rd_data
);

  logic [7:0] mem [MEM_DEPTH];
  logic [7:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_req.en) begin
      rd_data_r <= mem[rd_req.addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> rtl/sbr_frame_parser.sv
// Byte-level frame parser: header hunt, payload slot tracking, footer check.
module sbr_frame_parser
  import sbr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       byte_take,
  input  in_item_t   byte_in,
  input  cfg_regs_t  cfg,
  output parse_evt_t evt
);

  logic [4:0] pos_r,  pos_nxt;
  logic [7:0] prev_r, prev_nxt;
  logic [7:0] flag_r, flag_nxt;
  logic [4:0] pos_eff;
  logic [4:0] slot;

  function automatic logic is_footer(input logic [7:0] b, input cfg_regs_t c);
    return (b == c.footer_value) || ((b & c.alt_footer_mask) == c.alt_footer_value);
  endfunction

  assign pos_eff = byte_in.gap_timeout ? 5'd0 : pos_r;
  assign slot    = pos_eff - 5'd1;

  always_comb begin
    pos_nxt  = pos_r;
    prev_nxt = prev_r;
    flag_nxt = flag_r;
    evt      = '0;
    evt.wr_slot   = slot[SLOT_W-1:0];
    evt.wr_data   = byte_in.rx_byte;
    evt.flag_byte = flag_r;
    if (byte_take) begin
      prev_nxt = byte_in.rx_byte;
      if (pos_eff == 5'd0) begin
        pos_nxt = (byte_in.rx_byte == cfg.header_value && is_footer(prev_r, cfg)) ?
                  5'd1 : 5'd0;
      end else begin
        evt.wr_en = 1'b1;
        if (slot == 5'(FLAG_BYTE_IDX)) begin
          flag_nxt = byte_in.rx_byte;
        end
        if (slot == 5'(PAYLOAD_BYTES - 1)) begin
          pos_nxt        = 5'd0;
          evt.frame_good = is_footer(byte_in.rx_byte, cfg);
        end else begin
          pos_nxt = pos_eff + 5'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      prev_r <= '0;
    end else begin
      pos_r  <= pos_nxt;
      prev_r <= prev_nxt;
    end
    flag_r <= flag_nxt;
  end

endmodule

>>> rtl/sbr_channel_unpacker.sv
// Streams one stored frame out of memory and slices it into 11-bit channels.
module sbr_channel_unpacker
  import sbr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  drain_cmd_t cmd,
  output logic       busy,
  output mem_rd_t    rd_req,
  input  logic [7:0] rd_data,
  output logic       out_valid,
  input  logic       out_ready,
  output out_item_t  out_data
);

  // Wide enough that a read can be issued every cycle of an unstalled drain.
  localparam int ACC_W = CHAN_W + 15;

  logic             busy_r,     busy_nxt;
  logic             bank_r,     bank_nxt;
  logic             fs_r,       fs_nxt;
  logic             lf_r,       lf_nxt;
  logic             inflight_r, inflight_nxt;
  logic [4:0]       bcnt_r,     bcnt_nxt;
  logic [3:0]       ch_r,       ch_nxt;
  logic [ACC_W-1:0] acc_r,      acc_nxt;
  logic [4:0]       nbits_r,    nbits_nxt;
  logic             oval_r,     oval_nxt;
  out_item_t        odata_r,    odata_nxt;

  logic             out_free;
  logic             emit;
  logic [ACC_W-1:0] acc_sh;
  logic [4:0]       n_sh;
  logic [4:0]       projected;
  logic             issue;
  logic [MEM_AW-1:0] base;

  assign out_free  = !oval_r || out_ready;
  assign emit      = busy_r && (nbits_r >= 5'(CHAN_W)) && out_free;
  assign acc_sh    = emit ? (acc_r >> CHAN_W) : acc_r;
  assign n_sh      = emit ? (nbits_r - 5'(CHAN_W)) : nbits_r;
  assign projected = n_sh + (inflight_r ? 5'd8 : 5'd0);
  assign issue     = busy_r && (bcnt_r < 5'(CHAN_BYTES)) && (projected <= 5'(ACC_W - 8));
  assign base      = bank_r ? MEM_AW'(PAYLOAD_BYTES) : '0;

  assign rd_req.en   = issue;
  assign rd_req.addr = base + MEM_AW'(bcnt_r);

  always_comb begin
    busy_nxt     = busy_r;
    bank_nxt     = bank_r;
    fs_nxt       = fs_r;
    lf_nxt       = lf_r;
    inflight_nxt = issue;
    bcnt_nxt     = issue ? bcnt_r + 5'd1 : bcnt_r;
    ch_nxt       = ch_r;
    acc_nxt      = acc_sh;
    nbits_nxt    = n_sh;
    oval_nxt     = oval_r && !out_ready;
    odata_nxt    = odata_r;

    if (inflight_r) begin
      acc_nxt   = acc_sh | (ACC_W'(rd_data) << n_sh);
      nbits_nxt = n_sh + 5'd8;
    end

    if (emit) begin
      oval_nxt                  = 1'b1;
      odata_nxt.channel_index   = ch_r;
      odata_nxt.channel_value   = acc_r[CHAN_W-1:0];
      odata_nxt.failsafe_flag   = fs_r;
      odata_nxt.lost_frame_flag = lf_r;
      odata_nxt.last_channel    = (ch_r == 4'(CHAN_COUNT - 1));
      ch_nxt                    = ch_r + 4'd1;
      if (ch_r == 4'(CHAN_COUNT - 1)) begin
        busy_nxt = 1'b0;
      end
    end

    if (cmd.start) begin
      busy_nxt     = 1'b1;
      bank_nxt     = cmd.bank;
      fs_nxt       = cmd.failsafe;
      lf_nxt       = cmd.lost_frame;
      inflight_nxt = 1'b0;
      bcnt_nxt     = '0;
      ch_nxt       = '0;
      acc_nxt      = '0;
      nbits_nxt    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r     <= 1'b0;
      inflight_r <= 1'b0;
      oval_r     <= 1'b0;
      bcnt_r     <= '0;
      ch_r       <= '0;
      nbits_r    <= '0;
    end else begin
      busy_r     <= busy_nxt;
      inflight_r <= inflight_nxt;
      oval_r     <= oval_nxt;
      bcnt_r     <= bcnt_nxt;
      ch_r       <= ch_nxt;
      nbits_r    <= nbits_nxt;
    end
    bank_r  <= bank_nxt;
    fs_r    <= fs_nxt;
    lf_r    <= lf_nxt;
    acc_r   <= acc_nxt;
    odata_r <= odata_nxt;
  end

  assign busy      = busy_r;
  assign out_valid = oval_r;
  assign out_data  = odata_r;

endmodule

>>> rtl/sbus_frame_receiver.sv
// Top level of the SBUS frame receiver.
//
// SBUS frame receiver. Takes one UART byte per transaction on the in_
// channel, each tagged with gap_timeout (inter-byte timeout seen before the
// byte, which restarts the parser). A header byte starts a frame only when
// the byte before it was a footer (plain or SBUS2 masked). The next 24 bytes
// are written into a two-bank payload memory; if the last of them is a
// footer, the frame is handed to the unpacker and comes out as sixteen
// out_ transactions, channel 0 first, each with the failsafe and lost-frame
// flags from payload byte 22 and last_channel set on channel 15. A frame
// with a bad footer produces nothing. Rate: one input byte per cycle while
// in_ready is high. A good frame drains through the single memory read
// port, one byte read per cycle while the output is not stalled; with
// out_ready high, one frame's drain is over by the time the next frame's
// footer can arrive, so in_ready stays high. The two banks
// let one frame fill while the previous one drains; if a second good frame
// completes while the first is still draining (output backpressure),
// in_ready drops until the drain finishes. Configuration writes (cfg_ index
// 0..5, other indexes ignored) are always accepted and must be issued only
// while idle.
module sbus_frame_receiver
  import sbr_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_item_t            out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_data
);

  cfg_regs_t  cfg_r, cfg_nxt;
  logic       wbank_r, wbank_nxt;      // bank the parser writes into
  logic       pend_r, pend_nxt;        // completed frame waiting for unpacker
  logic [7:0] pend_flag_r, pend_flag_nxt;

  logic       byte_take;
  parse_evt_t evt;
  drain_cmd_t cmd;
  logic       unp_busy;
  mem_rd_t    rd_req;
  logic [7:0] rd_data;
  logic [MEM_AW-1:0] wr_addr;
  logic [7:0] start_flag;

  assign cfg_ready = 1'b1;
  assign in_ready  = !pend_r;
  assign byte_take = in_valid && in_ready;

  // Configuration registers
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        REG_HEADER:     cfg_nxt.header_value     = cfg_data;
        REG_FOOTER:     cfg_nxt.footer_value     = cfg_data;
        REG_ALT_MASK:   cfg_nxt.alt_footer_mask  = cfg_data;
        REG_ALT_FOOTER: cfg_nxt.alt_footer_value = cfg_data;
        REG_LOST_MASK:  cfg_nxt.lost_frame_mask  = cfg_data;
        REG_FS_MASK:    cfg_nxt.failsafe_mask    = cfg_data;
        default:        cfg_nxt = cfg_r;
      endcase
    end
  end

  sbr_frame_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .byte_take (byte_take),
    .byte_in   (in_data),
    .cfg       (cfg_r),
    .evt       (evt)
  );

  assign wr_addr = (wbank_r ? MEM_AW'(PAYLOAD_BYTES) : '0) + MEM_AW'(evt.wr_slot);

  sbr_payload_mem u_mem (
    .clk     (clk),
    .wr_en   (evt.wr_en),
    .wr_addr (wr_addr),
    .wr_data (evt.wr_data),
    .rd_req  (rd_req),
    .rd_data (rd_data)
  );

  // Bank hand-off: a good frame goes straight to the unpacker when it is
  // free, otherwise it is parked and the input is held off.
  always_comb begin
    wbank_nxt     = wbank_r;
    pend_nxt      = pend_r;
    pend_flag_nxt = pend_flag_r;
    cmd           = '0;
    start_flag    = evt.flag_byte;
    priority if (pend_r && !unp_busy) begin
      cmd.start  = 1'b1;
      start_flag = pend_flag_r;
      pend_nxt   = 1'b0;
      wbank_nxt  = !wbank_r;
    end else if (evt.frame_good && !unp_busy) begin
      cmd.start = 1'b1;
      wbank_nxt = !wbank_r;
    end else if (evt.frame_good) begin
      pend_nxt      = 1'b1;
      pend_flag_nxt = evt.flag_byte;
    end else begin
      pend_nxt = pend_r;
    end
    cmd.bank       = wbank_r;
    cmd.failsafe   = |(start_flag & cfg_r.failsafe_mask);
    cmd.lost_frame = |(start_flag & cfg_r.lost_frame_mask);
  end

  sbr_channel_unpacker u_unpacker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .busy      (unp_busy),
    .rd_req    (rd_req),
    .rd_data   (rd_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.header_value     <= 8'h0F;
      cfg_r.footer_value     <= 8'h00;
      cfg_r.alt_footer_mask  <= 8'h0F;
      cfg_r.alt_footer_value <= 8'h04;
      cfg_r.lost_frame_mask  <= 8'h04;
      cfg_r.failsafe_mask    <= 8'h08;
      wbank_r                <= 1'b0;
      pend_r                 <= 1'b0;
    end else begin
      cfg_r   <= cfg_nxt;
      wbank_r <= wbank_nxt;
      pend_r  <= pend_nxt;
    end
    pend_flag_r <= pend_flag_nxt;
  end

endmodule

>>> rtl/sbr_checker.sv
// Port-level checker for the SBUS frame receiver, with its bind.
module sbr_checker
  import sbr_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  logic [3:0] exp_idx_r, exp_idx_nxt;

  assign exp_idx_nxt = (out_valid && out_ready) ? exp_idx_r + 4'd1 : exp_idx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_idx_r <= '0;
    end else begin
      exp_idx_r <= exp_idx_nxt;
    end
  end

  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid high right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result transaction changed");

  a_index_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.channel_index == exp_idx_r)
    else $error("channel index out of sequence");

  a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.last_channel == (out_data.channel_index == 4'(CHAN_COUNT - 1)))
    else $error("last_channel does not match channel 15");

endmodule

bind sbus_frame_receiver sbr_checker u_sbr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

>>> sim/sbus_frame_receiver_test.sv
// Self-checking testbench for the SBUS frame receiver, with a built-in decoder model.
module sbus_frame_receiver_test;
  import sbr_pkg::*;

  // Body of a frame as the sender sees it: payload bytes 0..22 (channels and
  // flag byte). The 24th payload byte is the end byte and is passed apart.
  localparam int BODY_W = 8 * (PAYLOAD_BYTES - 1);

  // Indexes beyond the register file; writes there must change nothing.
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LOW = 8'd6;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_TOP = 8'hFF;

  // Long enough for a good frame's last channel to come out after its end
  // byte when nothing stalls; this also covers the bad-footer case where
  // nothing comes out at all.
  localparam int DRAIN_SETTLE = 40;

  // Cycles with no transaction on any channel before the run is abandoned.
  // The longest legal quiet stretch is the long receiver hold.
  localparam int QUIET_LIMIT = 2000;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [7:0]           cfg_data;

  sbus_frame_receiver i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Clock: 20 time units, starts low.
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Decoder model state. Configuration follows accepted cfg transactions,
  // parser state follows accepted in_ transactions.
  // ---------------------------------------------------------------------
  cfg_regs_t   model_cfg;
  logic [4:0]  frame_pos;                   // 0: hunting, n: n-1 bytes stored
  logic [7:0]  payload_mem [PAYLOAD_BYTES];
  logic [7:0]  prev_rx;                     // byte of the previous transaction
  out_item_t   expected_channels [$];       // channel results still to arrive

  int          mismatch_count;
  int          bytes_sent;
  int          in_stall_pct;                // sender idle chance per byte
  int          rx_stall_pct;                // receiver stall chance per cycle
  int          hold_cycles;                 // one long receiver hold on request
  int unsigned quiet_cycles;

  // Plain footer, or SBUS2 footer after masking.
  function automatic bit is_footer(input logic [7:0] b);
    return (b == model_cfg.footer_value) ||
           ((b & model_cfg.alt_footer_mask) == model_cfg.alt_footer_value);
  endfunction

  function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [7:0] val);
    unique case (idx)
      REG_HEADER:     model_cfg.header_value     = val;
      REG_FOOTER:     model_cfg.footer_value     = val;
      REG_ALT_MASK:   model_cfg.alt_footer_mask  = val;
      REG_ALT_FOOTER: model_cfg.alt_footer_value = val;
      REG_LOST_MASK:  model_cfg.lost_frame_mask  = val;
      REG_FS_MASK:    model_cfg.failsafe_mask    = val;
      default: ;  // unused index: ignored by the block
    endcase
  endfunction

  // Channels are packed LSB first across payload bytes 0..21, so the whole
  // channel area is one 176-bit little-endian word sliced every 11 bits.
  function automatic void queue_frame_channels();
    logic [8*CHAN_BYTES-1:0] chan_bits;
    logic                    fs;
    logic                    lf;
    out_item_t               r;
    int                      i;
    for (i = 0; i < CHAN_BYTES; i++) chan_bits[8*i +: 8] = payload_mem[i];
    fs = |(payload_mem[FLAG_BYTE_IDX] & model_cfg.failsafe_mask);
    lf = |(payload_mem[FLAG_BYTE_IDX] & model_cfg.lost_frame_mask);
    for (i = 0; i < CHAN_COUNT; i++) begin
      r.channel_index   = 4'(i);
      r.channel_value   = chan_bits[i*CHAN_W +: CHAN_W];
      r.failsafe_flag   = fs;
      r.lost_frame_flag = lf;
      r.last_channel    = (i == CHAN_COUNT - 1);
      expected_channels.push_back(r);
    end
  endfunction

  function automatic void decode_byte(input in_item_t it);
    // A timeout restarts the parser before the byte is looked at; the
    // previous byte is kept, so the new byte may still open a frame.
    if (it.gap_timeout) frame_pos = '0;
    if (frame_pos == 0) begin
      if (it.rx_byte == model_cfg.header_value && is_footer(prev_rx)) frame_pos = 5'd1;
    end else begin
      payload_mem[frame_pos - 5'd1] = it.rx_byte;
      if (frame_pos == PAYLOAD_BYTES) begin
        // End byte: good footer releases the frame, a bad one drops it.
        frame_pos = '0;
        if (is_footer(it.rx_byte)) queue_frame_channels();
      end else begin
        frame_pos = frame_pos + 5'd1;
      end
    end
    prev_rx = it.rx_byte;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic compare_field(input string name, input logic [3:0] chan,
                               input logic [10:0] want, input logic [10:0] got);
    if (got !== want)
      report_mismatch($sformatf("channel %0d %s: expected %0d, got %0d",
                                chan, name, want, got));
  endtask

  task automatic check_channel(input out_item_t got);
    out_item_t want;
    if (expected_channels.size() == 0) begin
      report_mismatch($sformatf("unexpected channel %0d value %0d",
                                got.channel_index, got.channel_value));
      return;
    end
    want = expected_channels.pop_front();
    compare_field("index",      want.channel_index, 11'(want.channel_index),
                  11'(got.channel_index));
    compare_field("value",      want.channel_index, want.channel_value,
                  got.channel_value);
    compare_field("failsafe",   want.channel_index, 11'(want.failsafe_flag),
                  11'(got.failsafe_flag));
    compare_field("lost_frame", want.channel_index, 11'(want.lost_frame_flag),
                  11'(got.lost_frame_flag));
    compare_field("last",       want.channel_index, 11'(want.last_channel),
                  11'(got.last_channel));
  endtask

  // Monitor: everything is sampled at the rising edge; inputs only move on
  // the falling edge, so sampled values are settled.
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) apply_reg(cfg_index, cfg_data);
      if (in_valid && in_ready) decode_byte(in_data);
      if (out_valid && out_ready) check_channel(out_data);
    end
  end

  // Watchdog: counts cycles with no transaction on any channel.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin : watchdog
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("watchdog: no transaction for %0d cycles, %0d channels outstanding",
             QUIET_LIMIT, expected_channels.size());
    $display("Test completed with failures");
    $finish;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
    return $urandom_range(1, 3);
  endfunction

  // Receiver side: random stalls, plus a long hold when a test asks for it.
  // The hold is counted here so the sender keeps running meanwhile.
  initial begin : receiver
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        out_ready = 1'b0;
        repeat (hold_cycles - 1) @(negedge clk);
        hold_cycles = 0;
      end else if ($urandom_range(0, 99) < rx_stall_pct) begin
        out_ready = 1'b0;
        repeat (pick_gap() - 1) @(negedge clk);
      end else begin
        out_ready = 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Sender tasks. All are entered and left at a falling edge.
  // ---------------------------------------------------------------------
  task automatic send_byte(input logic [7:0] b, input logic timeout);
    int gap;
    gap = ($urandom_range(0, 99) < in_stall_pct) ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid            = 1'b1;
    in_data.rx_byte     = b;
    in_data.gap_timeout = timeout;
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Block idle: all channels out, then time for a frame still in the drain.
  task automatic wait_idle();
    while (expected_channels.size() != 0) @(negedge clk);
    repeat (DRAIN_SETTLE) @(negedge clk);
  endtask

  // Header from the current config, 23 body bytes, then the end byte.
  task automatic send_frame(input logic hdr_timeout, input logic [BODY_W-1:0] body,
                            input logic [7:0] end_byte);
    int i;
    send_byte(model_cfg.header_value, hdr_timeout);
    for (i = 0; i < PAYLOAD_BYTES - 1; i++) send_byte(body[8*i +: 8], 1'b0);
    send_byte(end_byte, 1'b0);
  endtask

  function automatic logic [BODY_W-1:0] rand_body(input logic [7:0] flag_byte);
    logic [BODY_W-1:0] body;
    int                i;
    for (i = 0; i < PAYLOAD_BYTES - 1; i++) body[8*i +: 8] = 8'($urandom_range(0, 255));
    body[8*FLAG_BYTE_IDX +: 8] = flag_byte;
    return body;
  endfunction

  // A byte that passes the footer test, SBUS2 form where the masks allow it.
  function automatic logic [7:0] good_footer();
    logic [7:0] b;
    if ($urandom_range(0, 1) == 1 &&
        (model_cfg.alt_footer_value & ~model_cfg.alt_footer_mask) == 8'h00) begin
      b = 8'($urandom_range(0, 255));
      return (b & ~model_cfg.alt_footer_mask) | model_cfg.alt_footer_value;
    end
    return model_cfg.footer_value;
  endfunction

  task automatic randomize_config();
    logic [7:0] mask;
    mask = 8'($urandom_range(0, 255));
    write_reg(REG_HEADER,   8'($urandom_range(0, 255)));
    write_reg(REG_FOOTER,   8'($urandom_range(0, 255)));
    write_reg(REG_ALT_MASK, mask);
    // Mostly an SBUS2 value that fits under the mask, so it can match.
    if ($urandom_range(0, 3) != 0) write_reg(REG_ALT_FOOTER, 8'($urandom_range(0, 255)) & mask);
    else                           write_reg(REG_ALT_FOOTER, 8'($urandom_range(0, 255)));
    write_reg(REG_LOST_MASK, 8'($urandom_range(0, 255)));
    write_reg(REG_FS_MASK,   8'($urandom_range(0, 255)));
  endtask

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Reset config: header 0x0F, footer 0x00, SBUS2 footer xxxx0100.
  task automatic test_directed_frames();
    in_stall_pct = 10;
    rx_stall_pct = 10;
    // Timeout while hunting; the zero byte also leaves a footer behind.
    send_byte(8'h00, 1'b1);
    // All ones: every channel 0x7FF, both flags set; SBUS2 end byte.
    send_frame(1'b0, {(PAYLOAD_BYTES-1){8'hFF}}, 8'h14);
    // Partial frame, then a timeout on a header byte restarts the frame,
    // which ends in a bad end byte and is dropped.
    send_byte(8'h0F, 1'b0);
    send_byte(8'($urandom_range(0, 255)), 1'b0);
    send_byte(8'($urandom_range(0, 255)), 1'b0);
    send_byte(8'h00, 1'b0);
    send_frame(1'b1, rand_body(8'h04), 8'h01);
    // Header after a non-footer byte is not a frame start.
    send_byte(8'h0F, 1'b0);
    // Partial frame abandoned by a timeout on an ordinary byte.
    send_byte(8'h00, 1'b0);
    send_byte(8'h0F, 1'b0);
    send_byte(8'($urandom_range(0, 255)), 1'b0);
    send_byte(8'h55, 1'b1);
  endtask

  task automatic test_register_extremes();
    wait_idle();
    in_stall_pct = 30;
    rx_stall_pct = 30;
    // Mask and value zero: every byte counts as a footer.
    write_reg(REG_HEADER,     8'hFF);
    write_reg(REG_FOOTER,     8'hFF);
    write_reg(REG_ALT_MASK,   8'h00);
    write_reg(REG_ALT_FOOTER, 8'h00);
    write_reg(REG_LOST_MASK,  8'hFF);
    write_reg(REG_FS_MASK,    8'h00);
    // Out-of-range indexes must leave the registers alone.
    write_reg(REG_UNUSED_LOW, 8'($urandom_range(0, 255)));
    write_reg(REG_UNUSED_TOP, 8'($urandom_range(0, 255)));
    send_frame(1'b0, rand_body(8'($urandom_range(1, 255))), 8'($urandom_range(0, 255)));
  endtask

  // Random config. Receiver holds off while two frames arrive back to back:
  // both banks fill and the next byte finds in_ready low. Then the sender
  // waits for the full drain.
  task automatic test_output_backpressure();
    wait_idle();
    randomize_config();
    in_stall_pct = 0;
    rx_stall_pct = 0;
    hold_cycles  = 300;
    send_byte(good_footer(), 1'b0);
    repeat (2) send_frame(1'b0, rand_body(8'($urandom_range(0, 255))), good_footer());
    send_byte(8'($urandom_range(0, 255)), 1'b0);
    wait_idle();
  endtask

  // ---------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------
  initial begin
    clk            = 1'b0;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_data        = '0;
    cfg_valid      = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    mismatch_count = 0;
    bytes_sent     = 0;
    in_stall_pct   = 0;
    rx_stall_pct   = 0;
    hold_cycles    = 0;
    quiet_cycles   = 0;
    // Model reset values match the block's register reset values.
    model_cfg.header_value     = 8'h0F;
    model_cfg.footer_value     = 8'h00;
    model_cfg.alt_footer_mask  = 8'h0F;
    model_cfg.alt_footer_value = 8'h04;
    model_cfg.lost_frame_mask  = 8'h04;
    model_cfg.failsafe_mask    = 8'h08;
    frame_pos = '0;
    prev_rx   = 8'h00;

    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    test_directed_frames();
    test_register_extremes();
    test_output_backpressure();
    wait_idle();

    if (mismatch_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

>>> filelist.f
rtl/sbr_pkg.sv
rtl/sbr_payload_mem.sv
rtl/sbr_frame_parser.sv
rtl/sbr_channel_unpacker.sv
rtl/sbus_frame_receiver.sv
rtl/sbr_checker.sv
sim/sbus_frame_receiver_test.sv
